@@ rtl/ecv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_pkg
// Shared types, constants and the rounded Q30 product for the camera view
// matrix datapath.
// ----------------------------------------------------------------------------
package ecv_pkg;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [15:0] q14_t;
  typedef logic signed [32:0] raw_t;

  // Sine polynomial, Q30 coefficients, highest order first for Horner
  localparam int          HORNER_STEPS = 4;
  localparam logic [30:0] SIN_K9       = 31'd172272;
  localparam logic [30:0] HORNER_K [HORNER_STEPS] = '{
    31'd5026991, 31'd85569306, 31'd693598668, 31'd1686629713
  };
  // setup stage, Horner steps, scale stage, sign stage
  localparam int          SIN_STAGES   = HORNER_STEPS + 3;

  localparam logic [14:0] QUARTER_TURN = 15'd16384;
  localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
  localparam logic [14:0] ONE_Q14      = 15'd16384;

  localparam int          SQRT_STEPS   = 32;
  localparam int          QUOT_BITS    = 15;

  // Product of two Q30 values, rounded to nearest, ties away from zero.
  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] prod;
    logic [31:0] m;
    ua   = a[31] ? 32'(-a) : 32'(a);
    ub   = b[31] ? 32'(-b) : 32'(b);
    prod = ({32'b0, ua} * {32'b0, ub}) + (64'd1 << 29);
    m    = prod[61:30];
    mul_q30 = (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
  endfunction

endpackage

@@ rtl/ecv_sine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_sine
// Pipelined sine of a 16-bit binary angle, Q30 result, one word per cycle while adv is high.
// ----------------------------------------------------------------------------
module ecv_sine
  import ecv_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  logic [15:0] angle,
  output q30_t        sine
);

  logic [14:0] t_nxt;
  logic [29:0] tsq_nxt;
  logic [14:0] t_r   [HORNER_STEPS+1];
  logic [30:0] z2_r  [HORNER_STEPS];
  logic [30:0] p_r   [HORNER_STEPS];
  logic [HORNER_STEPS+1:0] neg_r;
  logic [45:0] scl_nxt;
  logic [30:0] mag_r;
  q30_t        sine_r;

  // fold the angle into the first quadrant
  always_comb begin
    t_nxt   = angle[14] ? (QUARTER_TURN - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    tsq_nxt = 30'(t_nxt) * 30'(t_nxt);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r[0]   <= t_nxt;
      z2_r[0]  <= {tsq_nxt[28:0], 2'b00};
      neg_r[0] <= angle[15];
      for (int k = 1; k <= HORNER_STEPS; k++) begin
        t_r[k] <= t_r[k-1];
      end
      for (int k = 1; k < HORNER_STEPS; k++) begin
        z2_r[k] <= z2_r[k-1];
      end
      for (int k = 1; k <= HORNER_STEPS + 1; k++) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    logic [30:0] p_in;
    logic [61:0] prod;
    if (k == 0) begin : g_first
      assign p_in = SIN_K9;
    end else begin : g_next
      assign p_in = p_r[k-1];
    end
    assign prod = 62'(p_in) * 62'(z2_r[k]);
    always_ff @(posedge clk) begin
      if (adv) begin
        p_r[k] <= HORNER_K[k] - prod[60:30];
      end
    end
  end

  assign scl_nxt = 46'(p_r[HORNER_STEPS-1]) * 46'(t_r[HORNER_STEPS]);

  always_ff @(posedge clk) begin
    if (adv) begin
      // clamp to one
      mag_r  <= ({2'b00, scl_nxt[45:14]} > {2'b00, ONE_Q30}) ? ONE_Q30[30:0]
                                                              : scl_nxt[44:14];
      sine_r <= neg_r[HORNER_STEPS+1] ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    end
  end

  assign sine = sine_r;

endmodule

@@ rtl/ecv_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_sqrt_cell
// One digit of a 64-bit integer square root, registered.
// ----------------------------------------------------------------------------
module ecv_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] rem_in,
  input  logic [63:0] root_in,
  output logic [63:0] rem_out,
  output logic [63:0] root_out
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [64:0] trial;
  logic [63:0] rem_r;
  logic [63:0] root_r;

  assign trial = {1'b0, root_in} + {1'b0, BIT};

  always_ff @(posedge clk) begin
    if (adv) begin
      if ({1'b0, rem_in} >= trial) begin
        rem_r  <= rem_in - trial[63:0];
        root_r <= (root_in >> 1) + BIT;
      end else begin
        rem_r  <= rem_in;
        root_r <= root_in >> 1;
      end
    end
  end

  assign rem_out  = rem_r;
  assign root_out = root_r;

endmodule

@@ rtl/ecv_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_div_cell
// One quotient bit of three restoring divisions sharing a divisor.
// ----------------------------------------------------------------------------
module ecv_div_cell #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            adv,
  input  logic [32:0]     den_in,
  input  logic [2:0][47:0] rem_in,
  input  logic [2:0][14:0] quo_in,
  output logic [32:0]     den_out,
  output logic [2:0][47:0] rem_out,
  output logic [2:0][14:0] quo_out
);

  logic [47:0]       trial;
  logic [32:0]       den_r;
  logic [2:0][47:0]  rem_r;
  logic [2:0][14:0]  quo_r;

  assign trial = 48'(den_in) << BIT;

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r <= den_in;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= trial) begin
          rem_r[i] <= rem_in[i] - trial;
          quo_r[i] <= quo_in[i] | (15'd1 << BIT);
        end else begin
          rem_r[i] <= rem_in[i];
          quo_r[i] <= quo_in[i];
        end
      end
    end
  end

  assign den_out = den_r;
  assign rem_out = rem_r;
  assign quo_out = quo_r;

endmodule

@@ rtl/ecv_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecv_norm
// Pipelined normalization of a 3-vector to Q2.14: squares, a chain of
// square-root cells, then a chain of divider cells. Carries a side word.
// ----------------------------------------------------------------------------
module ecv_norm
  import ecv_pkg::*;
#(
  parameter int PW = 96
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  raw_t          in_v [3],
  input  logic [PW-1:0] in_pass,
  output logic          out_valid,
  output q14_t          out_v [3],
  output logic [PW-1:0] out_pass
);

  localparam int NP = SQRT_STEPS + 2;
  localparam int ND = QUOT_BITS + 1;

  logic [31:0]      mag_w  [3];
  logic [2:0]       sgn_w;
  logic [63:0]      sq_r   [3];
  logic [63:0]      sum_r;
  logic [31:0]      mag_r  [NP][3];
  logic [2:0]       sgn_r  [NP];
  logic [PW-1:0]    pass_r [NP];
  logic [NP-1:0]    vld_r;
  logic [63:0]      rem_w  [SQRT_STEPS];
  logic [63:0]      root_w [SQRT_STEPS];
  logic [31:0]      len_w;
  logic [32:0]      den_r;
  logic [2:0][47:0] num_r;
  logic [32:0]      den_w  [QUOT_BITS];
  logic [2:0][47:0] drem_w [QUOT_BITS];
  logic [2:0][14:0] quo_w  [QUOT_BITS];
  logic [PW-1:0]    dpass_r [ND];
  logic [2:0]       dsgn_r  [ND];
  logic [ND-1:0]    dzero_r;
  logic [ND-1:0]    dvld_r;
  q14_t             out_r  [3];
  logic [PW-1:0]    opass_r;
  logic             ovld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sgn_w[i] = in_v[i][32];
      mag_w[i] = in_v[i][32] ? 32'(-in_v[i]) : 32'(in_v[i]);
    end
  end

  // valid line, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      dvld_r <= '0;
      ovld_r <= 1'b0;
    end else if (adv) begin
      vld_r  <= {vld_r[NP-2:0], in_valid};
      dvld_r <= {dvld_r[ND-2:0], vld_r[NP-1]};
      ovld_r <= dvld_r[ND-1];
    end
  end

  // squares and their sum, side data through the root chain
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[0][i] <= mag_w[i];
        sq_r[i]     <= 64'(mag_w[i]) * 64'(mag_w[i]);
      end
      sgn_r[0]  <= sgn_w;
      pass_r[0] <= in_pass;
      sum_r     <= sq_r[0] + sq_r[1] + sq_r[2];
      for (int k = 1; k < NP; k++) begin
        mag_r[k]  <= mag_r[k-1];
        sgn_r[k]  <= sgn_r[k-1];
        pass_r[k] <= pass_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
    if (k == 0) begin : g_first
      ecv_sqrt_cell #(.STEP(k)) u_cell (
        .clk(clk), .adv(adv), .rem_in(sum_r), .root_in(64'd0),
        .rem_out(rem_w[k]), .root_out(root_w[k])
      );
    end else begin : g_next
      ecv_sqrt_cell #(.STEP(k)) u_cell (
        .clk(clk), .adv(adv), .rem_in(rem_w[k-1]), .root_in(root_w[k-1]),
        .rem_out(rem_w[k]), .root_out(root_w[k])
      );
    end
  end

  assign len_w = root_w[SQRT_STEPS-1][31:0];

  // set up numerators m*2^15 + len over divisor 2*len
  always_ff @(posedge clk) begin
    if (adv) begin
      den_r <= {len_w, 1'b0};
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= {1'b0, mag_r[NP-1][i], 15'b0} + 48'(len_w);
      end
      dzero_r[0] <= (len_w == 32'd0);
      dsgn_r[0]  <= sgn_r[NP-1];
      dpass_r[0] <= pass_r[NP-1];
      for (int k = 1; k < ND; k++) begin
        dzero_r[k] <= dzero_r[k-1];
        dsgn_r[k]  <= dsgn_r[k-1];
        dpass_r[k] <= dpass_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_quot
    if (k == 0) begin : g_first
      ecv_div_cell #(.BIT(QUOT_BITS - 1 - k)) u_cell (
        .clk(clk), .adv(adv), .den_in(den_r), .rem_in(num_r), .quo_in('0),
        .den_out(den_w[k]), .rem_out(drem_w[k]), .quo_out(quo_w[k])
      );
    end else begin : g_next
      ecv_div_cell #(.BIT(QUOT_BITS - 1 - k)) u_cell (
        .clk(clk), .adv(adv), .den_in(den_w[k-1]), .rem_in(drem_w[k-1]),
        .quo_in(quo_w[k-1]),
        .den_out(den_w[k]), .rem_out(drem_w[k]), .quo_out(quo_w[k])
      );
    end
  end

  // clamp, apply sign, zero vector when the length is zero
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [14:0] q;
        q = (quo_w[QUOT_BITS-1][i] > ONE_Q14) ? ONE_Q14 : quo_w[QUOT_BITS-1][i];
        if (dzero_r[ND-1]) begin
          out_r[i] <= '0;
        end else if (dsgn_r[ND-1][i]) begin
          out_r[i] <= -$signed({1'b0, q});
        end else begin
          out_r[i] <= $signed({1'b0, q});
        end
      end
      opass_r <= dpass_r[ND-1];
    end
  end

  assign out_valid = ovld_r;
  assign out_v     = out_r;
  assign out_pass  = opass_r;

endmodule

@@ rtl/euler_camera_view_matrix.sv @@
`timescale 1ns / 1ps
// Depth: 167 register stages from the input register to the output register.
// Throughput: one word per cycle while out_stall does not hold the pipeline;
//   the three normalizers (2 + 32 root cells + 1 + 15 divider cells + 1 stages
//   each) set the depth, not the rate.
// Stall: the whole pipeline holds while the output register is full and
//   stalled. Reset (rst_n, synchronous) clears all valid bits only.
// ----------------------------------------------------------------------------
// euler_camera_view_matrix
// View matrix from camera position and X/Y/Z Euler angles: look, right and up
// unit vectors in Q2.14 and the Q16.16 translation row.
// ----------------------------------------------------------------------------
module euler_camera_view_matrix
  import ecv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [15:0] in_angle_x,
  input  logic [15:0] in_angle_y,
  input  logic [15:0] in_angle_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_right_x,
  output logic [15:0] out_up_x,
  output logic [15:0] out_look_x,
  output logic [15:0] out_right_y,
  output logic [15:0] out_up_y,
  output logic [15:0] out_look_y,
  output logic [15:0] out_right_z,
  output logic [15:0] out_up_z,
  output logic [15:0] out_look_z,
  output logic [31:0] out_trans_right,
  output logic [31:0] out_trans_up,
  output logic [31:0] out_trans_look
);

  // every stage moves together; hold all while the output word waits
  logic adv;

  // input register
  logic [95:0] pos_r;
  logic [15:0] ang_r [3];
  logic        v0_r;

  // sine outputs, position line alongside the sine pipes
  q30_t        sin_w [3];
  q30_t        cos_w [3];
  logic [95:0] spos_r [SIN_STAGES];
  logic [SIN_STAGES-1:0] svld_r;

  // trig products
  q30_t        cxsy_r, cxcy_r, sxsz_r, sxcz_r, sz_r, cz_r;
  logic [95:0] m1pos_r;
  logic        m1vld_r;
  raw_t        raw_r [3];
  logic [95:0] m2pos_r;
  logic        m2vld_r;

  // look
  q14_t        look_w [3];
  logic [95:0] lpos_w;
  logic        lvld_w;

  // right
  raw_t        rraw_w [3];
  q14_t        rt_w   [3];
  logic [143:0] rpass_w;
  logic        rvld_w;

  // cross product for up
  logic signed [31:0] cp_w [6];
  raw_t        xraw_r [3];
  logic [191:0] xpass_r;
  logic        xvld_r;

  // up
  q14_t        up_w [3];
  logic [191:0] upass_w;
  logic        uvld_w;

  // translation stages; rows: right, up, look
  logic [95:0]        vec_w  [3];
  logic [95:0]        pos_w;
  logic signed [47:0] prod_r [3][3];
  logic [95:0]        t1vec_r [3];
  logic signed [49:0] neg_r  [3];
  logic [95:0]        t2vec_r [3];
  logic [31:0]        trans_r [3];
  logic [95:0]        ovec_r  [3];
  logic               t1vld_r, t2vld_r, ovld_r;

  // round a negated Q30 dot product to Q16.16, ties away from zero, saturate
  function automatic logic [31:0] round_sat(input logic signed [49:0] s);
    logic [49:0] m;
    logic [49:0] rs;
    logic [36:0] r;
    m  = s[49] ? 50'(-s) : 50'(s);
    rs = (m + 50'd8192) >> 14;
    r  = rs[36:0];
    if (s[49]) begin
      round_sat = (r > 37'h0_8000_0000) ? 32'h8000_0000 : 32'(-r);
    end else begin
      round_sat = (r > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end
  endfunction

  assign adv      = !ovld_r || !out_stall;
  // refuse input words while reset is held
  assign in_stall = !adv || !rst_n;

  // ---------------------------------------------------------------- valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      svld_r  <= '0;
      m1vld_r <= 1'b0;
      m2vld_r <= 1'b0;
      xvld_r  <= 1'b0;
      t1vld_r <= 1'b0;
      t2vld_r <= 1'b0;
      ovld_r  <= 1'b0;
    end else if (adv) begin
      v0_r    <= in_valid;
      svld_r  <= {svld_r[SIN_STAGES-2:0], v0_r};
      m1vld_r <= svld_r[SIN_STAGES-1];
      m2vld_r <= m1vld_r;
      xvld_r  <= rvld_w;
      t1vld_r <= uvld_w;
      t2vld_r <= t1vld_r;
      ovld_r  <= t2vld_r;
    end
  end

  // ---------------------------------------------------------- input register
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r    <= {in_pos_x, in_pos_y, in_pos_z};
      ang_r[0] <= in_angle_x;
      ang_r[1] <= in_angle_y;
      ang_r[2] <= in_angle_z;
    end
  end

  // ------------------------------------------------------- sines and cosines
  // cosine is the sine a quarter turn ahead
  for (genvar i = 0; i < 3; i++) begin : g_trig
    ecv_sine u_sin (
      .clk(clk), .adv(adv), .angle(ang_r[i]), .sine(sin_w[i])
    );
    ecv_sine u_cos (
      .clk(clk), .adv(adv), .angle(16'(ang_r[i] + 16'h4000)), .sine(cos_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      spos_r[0] <= pos_r;
      for (int k = 1; k < SIN_STAGES; k++) begin
        spos_r[k] <= spos_r[k-1];
      end
    end
  end

  // --------------------------------------------------- rotate forward vector
  // look = (cx*sy*cz + sx*sz, cx*sy*sz - sx*cz, cx*cy)
  always_ff @(posedge clk) begin
    if (adv) begin
      cxsy_r  <= mul_q30(cos_w[0], sin_w[1]);
      cxcy_r  <= mul_q30(cos_w[0], cos_w[1]);
      sxsz_r  <= mul_q30(sin_w[0], sin_w[2]);
      sxcz_r  <= mul_q30(sin_w[0], cos_w[2]);
      sz_r    <= sin_w[2];
      cz_r    <= cos_w[2];
      m1pos_r <= spos_r[SIN_STAGES-1];

      raw_r[0] <= 33'(mul_q30(cxsy_r, cz_r)) + 33'(sxsz_r);
      raw_r[1] <= 33'(mul_q30(cxsy_r, sz_r)) - 33'(sxcz_r);
      raw_r[2] <= 33'(cxcy_r);
      m2pos_r  <= m1pos_r;
    end
  end

  ecv_norm #(.PW(96)) u_norm_look (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(m2vld_r), .in_v(raw_r), .in_pass(m2pos_r),
    .out_valid(lvld_w), .out_v(look_w), .out_pass(lpos_w)
  );

  // ------------------------------------------- right = norm(up_world x look)
  assign rraw_w[0] = 33'(look_w[2]);
  assign rraw_w[1] = '0;
  assign rraw_w[2] = -33'(look_w[0]);

  ecv_norm #(.PW(144)) u_norm_right (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(lvld_w), .in_v(rraw_w),
    .in_pass({lpos_w, look_w[0], look_w[1], look_w[2]}),
    .out_valid(rvld_w), .out_v(rt_w), .out_pass(rpass_w)
  );

  // --------------------------------------------------- up = look x right
  always_comb begin
    q14_t lk [3];
    lk[0] = $signed(rpass_w[47:32]);
    lk[1] = $signed(rpass_w[31:16]);
    lk[2] = $signed(rpass_w[15:0]);
    cp_w[0] = 32'(lk[1]) * 32'(rt_w[2]);
    cp_w[1] = 32'(lk[2]) * 32'(rt_w[1]);
    cp_w[2] = 32'(lk[2]) * 32'(rt_w[0]);
    cp_w[3] = 32'(lk[0]) * 32'(rt_w[2]);
    cp_w[4] = 32'(lk[0]) * 32'(rt_w[1]);
    cp_w[5] = 32'(lk[1]) * 32'(rt_w[0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xraw_r[0] <= 33'(cp_w[0]) - 33'(cp_w[1]);
      xraw_r[1] <= 33'(cp_w[2]) - 33'(cp_w[3]);
      xraw_r[2] <= 33'(cp_w[4]) - 33'(cp_w[5]);
      xpass_r   <= {rpass_w, rt_w[0], rt_w[1], rt_w[2]};
    end
  end

  ecv_norm #(.PW(192)) u_norm_up (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(xvld_r), .in_v(xraw_r), .in_pass(xpass_r),
    .out_valid(uvld_w), .out_v(up_w), .out_pass(upass_w)
  );

  // ------------------------------------------------------------ translation
  // side word from the up normalizer: pos, look, right
  assign pos_w    = upass_w[191:96];
  assign vec_w[0] = {{16{1'b0}}, 80'(upass_w[47:0])};
  assign vec_w[1] = {{16{1'b0}}, 32'b0, up_w[0], up_w[1], up_w[2]};
  assign vec_w[2] = {{16{1'b0}}, 80'(upass_w[95:48])};

  always_ff @(posedge clk) begin
    if (adv) begin
      // pos * vec, one product per lane
      for (int v = 0; v < 3; v++) begin
        for (int j = 0; j < 3; j++) begin
          logic signed [31:0] p;
          logic signed [15:0] c;
          p = $signed(pos_w[95 - 32*j -: 32]);
          c = $signed(vec_w[v][47 - 16*j -: 16]);
          prod_r[v][j] <= 48'(p) * 48'(c);
        end
        t1vec_r[v] <= vec_w[v];
      end

      // negate the sum
      for (int v = 0; v < 3; v++) begin
        neg_r[v]   <= -(50'(prod_r[v][0]) + 50'(prod_r[v][1]) + 50'(prod_r[v][2]));
        t2vec_r[v] <= t1vec_r[v];
      end

      // round and saturate into the output word
      for (int v = 0; v < 3; v++) begin
        trans_r[v] <= round_sat(neg_r[v]);
        ovec_r[v]  <= t2vec_r[v];
      end
    end
  end

  // ------------------------------------------------------------------ outputs
  assign out_valid       = ovld_r;
  assign out_right_x     = ovec_r[0][47:32];
  assign out_right_y     = ovec_r[0][31:16];
  assign out_right_z     = ovec_r[0][15:0];
  assign out_up_x        = ovec_r[1][47:32];
  assign out_up_y        = ovec_r[1][31:16];
  assign out_up_z        = ovec_r[1][15:0];
  assign out_look_x      = ovec_r[2][47:32];
  assign out_look_y      = ovec_r[2][31:16];
  assign out_look_z      = ovec_r[2][15:0];
  assign out_trans_right = trans_r[0];
  assign out_trans_up    = trans_r[1];
  assign out_trans_look  = trans_r[2];

  // --------------------------------------------------------------- assertions
  // right is built from (look_z, 0, -look_x), so its y part is always zero
  a_right_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_right_y == 16'd0)
    else $error("right vector has a y component");

  // look_x and up_y, two of the unit entries, stay within plus or minus one
  a_look_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_look_x) <= 16'sd16384 && $signed(out_look_x) >= -16'sd16384
                && $signed(out_up_y) <= 16'sd16384 && $signed(out_up_y) >= -16'sd16384))
    else $error("rotation entry out of range");

  // looking straight along y: right and up collapse to zero
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_look_x == 16'd0 && out_look_z == 16'd0
      |-> out_right_x == 16'd0 && out_up_y == 16'd0 && out_trans_right == 32'd0)
    else $error("degenerate look did not give zero right and up");

  // the pipeline holds a stalled output word in place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_trans_look) && $stable(out_up_z))
    else $error("stalled output word changed");

endmodule

@@ test/tb_euler_camera_view_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_camera_view_matrix
// Streams camera poses through the view matrix pipeline and compares each
// result word, field by field, against a bit-exact fixed-point predictor.
// Covers extreme positions and angles, the degenerate look-along-Y pose,
// saturation of the translation row, random gaps on both sides, a long
// receiver hold that backs up the pipeline, and a full drain pause.
// ----------------------------------------------------------------------------
module tb_euler_camera_view_matrix;
  import ecv_pkg::*;

  localparam int N_RANDOM   = 1250;
  localparam int IDLE_LIMIT = 2000;  // cycles with no word moving on any side
  localparam int TAIL_WAIT  = 200;   // > pipeline depth of 167 stages

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_right_x, out_up_x, out_look_x;
  logic [15:0] out_right_y, out_up_y, out_look_y;
  logic [15:0] out_right_z, out_up_z, out_look_z;
  logic [31:0] out_trans_right, out_trans_up, out_trans_look;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_camera_view_matrix i_dut (.*);

  typedef longint vec3_t[3];

  // One view matrix: rotation entries in port order, then translations.
  typedef struct {
    logic [15:0] rot[9];
    logic [31:0] tr[3];
  } view_t;

  // ---------------------------------------------------------------- predictor
  // Sine of a binary angle in Q30: mirror by quadrant, quarter-wave polynomial,
  // Horner steps truncate, clamp to one, then negate by quadrant.
  function automatic longint sine_q30(input longint unsigned ang);
    longint unsigned quad, rem, t, z2, p;
    quad = (ang >> 14) & 3;
    rem  = ang & 64'h3FFF;
    t    = quad[0] ? (64'd16384 - rem) : rem;
    z2   = t * t * 4;
    p    = 64'(SIN_K9);
    for (int i = 0; i < HORNER_STEPS; i++)
      p = 64'(HORNER_K[i]) - ((p * z2) >> 30);
    p = (p * t) >> 14;
    if (p > 64'd1073741824) p = 64'd1073741824;
    return quad[1] ? -longint'(p) : longint'(p);
  endfunction

  // Q30 product, round to nearest, ties away from zero.
  function automatic longint q30_product(input longint a, input longint b);
    longint unsigned ua, ub, m;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    m  = (ua * ub + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale to unit length in Q2.14; a zero vector stays zero.
  function automatic vec3_t unit_q14(input vec3_t v);
    vec3_t o;
    longint unsigned n2, len, m, q;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      n2 += m * m;
    end
    len = floor_root(n2);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        o[i] = 0;
      end else begin
        m = (v[i] < 0) ? -v[i] : v[i];
        q = (m * 2 * 16384 + len) / (2 * len);
        if (q > 16384) q = 16384;
        o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    return o;
  endfunction

  // -(p . v) rounded from Q30 to Q16.16 and saturated to 32 bits.
  function automatic logic [31:0] neg_dot_q16(input vec3_t p, input vec3_t v);
    longint s;
    longint unsigned m;
    s = -(p[0] * v[0] + p[1] * v[1] + p[2] * v[2]);
    m = (s < 0) ? -s : s;
    m = (m + (64'd1 << 13)) >> 14;
    if (s < 0) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(-longint'(m));
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return 32'(m);
  endfunction

  function automatic view_t predict_view(input logic [31:0] px, py, pz,
                                         input logic [15:0] ax, ay, az);
    view_t  v;
    vec3_t  pos, raw, lk, rt, up;
    longint sx, cx, sy, cy, sz, cz, cxsy;
    pos[0] = longint'($signed(px));
    pos[1] = longint'($signed(py));
    pos[2] = longint'($signed(pz));
    sx = sine_q30(ax);
    cx = sine_q30(16'(ax + 16'd16384));
    sy = sine_q30(ay);
    cy = sine_q30(16'(ay + 16'd16384));
    sz = sine_q30(az);
    cz = sine_q30(16'(az + 16'd16384));
    cxsy   = q30_product(cx, sy);
    raw[0] = q30_product(cxsy, cz) + q30_product(sx, sz);
    raw[1] = q30_product(cxsy, sz) - q30_product(sx, cz);
    raw[2] = q30_product(cx, cy);
    lk = unit_q14(raw);
    raw[0] = lk[2];
    raw[1] = 0;
    raw[2] = -lk[0];
    rt = unit_q14(raw);
    raw[0] = lk[1] * rt[2] - lk[2] * rt[1];
    raw[1] = lk[2] * rt[0] - lk[0] * rt[2];
    raw[2] = lk[0] * rt[1] - lk[1] * rt[0];
    up = unit_q14(raw);
    for (int i = 0; i < 3; i++) begin
      v.rot[i*3+0] = 16'(rt[i]);
      v.rot[i*3+1] = 16'(up[i]);
      v.rot[i*3+2] = 16'(lk[i]);
    end
    v.tr[0] = neg_dot_q16(pos, rt);
    v.tr[1] = neg_dot_q16(pos, up);
    v.tr[2] = neg_dot_q16(pos, lk);
    return v;
  endfunction

  // --------------------------------------------------------------- scoreboard
  class view_scoreboard;
    view_t pending[$];
    int    n_bad;
    int    n_checked;
    string rot_name[9] = '{"right_x", "up_x", "look_x", "right_y", "up_y",
                           "look_y", "right_z", "up_z", "look_z"};
    string tr_name[3]  = '{"trans_right", "trans_up", "trans_look"};

    function void note_pose(input logic [31:0] px, py, pz,
                            input logic [15:0] ax, ay, az);
      pending.push_back(predict_view(px, py, pz, ax, ay, az));
    endfunction

    function void flag(input string what, input logic [31:0] exp_v, act_v);
      n_bad++;
      if (n_bad <= 10)
        $display("[%0t] mismatch #%0d word %0d %s: expected %h got %h",
                 $realtime, n_bad, n_checked, what, exp_v, act_v);
    endfunction

    function void check_view(input view_t got);
      view_t want;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("[%0t] result word with none pending", $realtime);
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.rot[i] !== want.rot[i]) flag(rot_name[i], want.rot[i], got.rot[i]);
      for (int i = 0; i < 3; i++)
        if (got.tr[i] !== want.tr[i]) flag(tr_name[i], want.tr[i], got.tr[i]);
      n_checked++;
    endfunction
  endclass

  view_scoreboard sb = new();

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ----------------------------------------------------------------- sender
  // Present one word and hold it until the block takes it.
  task automatic put_pose(input logic [31:0] px, py, pz,
                          input logic [15:0] ax, ay, az);
    in_valid   <= 1'b1;
    in_pos_x   <= px;
    in_pos_y   <= py;
    in_pos_z   <= pz;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    do @(posedge clk); while (in_stall);
    sb.note_pose(px, py, pz, ax, ay, az);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Position: full random, small, or an extreme value.
  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom();
      3:       return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
    endcase
  endfunction

  // Angle: full random, or a quarter-turn point with small jitter.
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 3) == 0)
      return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 4) - 2);
    return 16'($urandom());
  endfunction

  initial begin
    logic [15:0] quarter[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                16'hFFFF, 16'h2000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each axis through the quarter points.
    for (int i = 0; i < 6; i++)
      put_pose(32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000,
               quarter[i], quarter[(i + 2) % 6], quarter[(i + 4) % 6]);
    // Look straight down Y: right and up degenerate to zero.
    put_pose(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 16'h4000, 16'h1234, 16'h0000);
    put_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hC000, 16'h0000, 16'h8000);
    // Translation saturation both ways.
    put_pose(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 16'h0000, 16'h0000, 16'h0000);
    put_pose(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 16'h0000, 16'h0000, 16'h0000);
    put_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1000, 16'h2000, 16'h0000);
    put_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h1000, 16'h2000, 16'h0000);
    put_pose(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    put_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 16'h5555, 16'hAAAA, 16'h3333);
    put_pose(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 16'hAAAA, 16'h5555, 16'hCCCC);

    for (int n = 0; n < N_RANDOM; n++) begin
      put_pose(pick_pos(), pick_pos(), pick_pos(), pick_angle(), pick_angle(),
               pick_angle());
      // Every third stretch of 100 words runs back to back.
      if ((n / 100) % 3 != 0) idle_for(pick_gap());
      if (n == 700) drain();
    end
    drain();
    repeat (TAIL_WAIT) @(posedge clk);

    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("** euler_camera_view_matrix: PASSED **");
    end else begin
      $display("** euler_camera_view_matrix: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // Take result words, then choose the stall for the next edge. Once, after
  // a few hundred words, hold off long enough for the pipeline to fill.
  initial begin
    view_t got;
    int    hold_left = 0;
    bit    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.rot = '{out_right_x, out_up_x, out_look_x, out_right_y, out_up_y,
                    out_look_y, out_right_z, out_up_z, out_look_z};
        got.tr  = '{out_trans_right, out_trans_up, out_trans_look};
        sb.check_view(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_done && sb.n_checked >= 300) begin
        long_done = 1'b1;
        hold_left = 600;
        out_stall <= 1'b1;
      end else if ((sb.n_checked / 150) % 3 == 1) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        hold_left = $urandom_range(20, 60);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  initial begin
    int quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("** euler_camera_view_matrix: FAILED **");
        $finish;
      end
    end
  end

endmodule

@@ euler_camera_view_matrix.f @@
rtl/ecv_pkg.sv
rtl/ecv_sine.sv
rtl/ecv_sqrt_cell.sv
rtl/ecv_div_cell.sv
rtl/ecv_norm.sv
rtl/euler_camera_view_matrix.sv
test/tb_euler_camera_view_matrix.sv
